// File: sv/bpa_pkg.sv
// bpa_pkg: shared constants, codes and request structs of the buddy page allocator
// used by bpa_meta_store, bpa_link_store and buddy_page_allocator
package bpa_pkg;

  localparam int NUM_PAGES  = 64;
  localparam int NUM_ORDERS = 7;
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int LINK_W     = PAGE_W + 1;
  localparam int ORD_W      = $clog2(NUM_ORDERS);

  // null link and zone limit
  localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(NUM_PAGES);
  localparam logic [LINK_W-1:0] MAX_PAGES = LINK_W'(NUM_PAGES);

  // action codes
  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADORD  = 2'd2;

  // per-page metadata
  typedef struct packed {
    logic             in_use;
    logic             head;
    logic [ORD_W-1:0] order;
  } meta_t;

  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic [PAGE_W-1:0] rd_addr;
    logic              wr_en;
    logic [PAGE_W-1:0] wr_addr;
    meta_t             wr_data;
  } meta_req_t;

  typedef struct packed {
    logic              rd_en;
    logic [PAGE_W-1:0] rd_addr;
    logic              nx_we;
    logic [PAGE_W-1:0] nx_addr;
    logic [LINK_W-1:0] nx_data;
    logic              pv_we;
    logic [PAGE_W-1:0] pv_addr;
    logic [LINK_W-1:0] pv_data;
  } link_req_t;

  typedef struct packed {
    logic [LINK_W-1:0] nx;
    logic [LINK_W-1:0] pv;
  } link_rd_t;

endpackage

// File: sv/buddy_page_allocator.sv
// buddy_page_allocator: top level, command sequencer, free-list heads and result register
// depends on bpa_pkg, bpa_meta_store, bpa_link_store
//
// channel | dir | fields
// s_*     | in  | tuser: action[1:0]; tdata: block_order[3:0], page_index[9:4], zero pad
// m_*     | out | tuser: status[1:0]; tdata: alloc_page[5:0], zero pad
// cfg_*   | in  | cfg_data: page_count[6:0]
//
// one item at a time; init clears, cuts the zone into head blocks, then checks
// the end; allocate pops a list head and splits it one level per step; free
// checks the page, merges with free buddies one level per step, then pushes
// the block; an unused action goes straight to done. each item then loads the
// result register; lookups are registered reads. reset empties all lists and
// the zone; no clearing pass. a stalled result holds while the next item is accepted.
module buddy_page_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // block_order[3:0], page_index[9:4]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // alloc_page[5:0]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // page_count[6:0]
);
  import bpa_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INIT_CLR = 4'd1;
  localparam logic [3:0] S_INIT_CUT = 4'd2;
  localparam logic [3:0] S_A_FIND   = 4'd3;
  localparam logic [3:0] S_A_UNLINK = 4'd4;
  localparam logic [3:0] S_A_SPLIT  = 4'd5;
  localparam logic [3:0] S_F_CHK    = 4'd6;
  localparam logic [3:0] S_F_CHK2   = 4'd7;
  localparam logic [3:0] S_F_BUD    = 4'd8;
  localparam logic [3:0] S_F_BCHK   = 4'd9;
  localparam logic [3:0] S_F_PUSH   = 4'd10;
  localparam logic [3:0] S_F_PUSH2  = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0]          state, state_next;
  logic [3:0]          ord, ord_next;
  logic [PAGE_W-1:0]   pg, pg_next;
  logic [ORD_W-1:0]    lvl, lvl_next;
  logic [LINK_W-1:0]   off, off_next;
  logic [LINK_W-1:0]   zone, zone_next;
  logic [LINK_W-1:0]   hold, hold_next;
  logic [6:0]          page_count;
  logic [LINK_W-1:0]   list_first [NUM_ORDERS];
  logic [LINK_W-1:0]   list_first_next [NUM_ORDERS];
  logic [NUM_ORDERS-1:0] mask, mask_next;
  logic [1:0]          res_status, res_status_next;
  logic [PAGE_W-1:0]   res_page, res_page_next;
  logic [1:0]          out_status;
  logic [PAGE_W-1:0]   out_page;
  logic                out_load;

  meta_req_t meta_req;
  meta_t     meta_rd;
  link_req_t link_req;
  link_rd_t  link_rd;

  bpa_meta_store u_meta (
    .clk     (clk),
    .rst     (rst),
    .req     (meta_req),
    .rd_data (meta_rd)
  );

  bpa_link_store u_link (
    .clk     (clk),
    .req     (link_req),
    .rd_data (link_rd)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);
  assign m_tdata   = {2'b00, out_page};
  assign m_tuser   = out_status;

  // sequencer
  always_comb begin
    logic [LINK_W-1:0] rest;
    logic [ORD_W-1:0]  kcut;
    logic [ORD_W-1:0]  sidx;
    logic              found;
    logic [ORD_W-1:0]  nl;
    logic [PAGE_W-1:0] bud;
    logic [LINK_W-1:0] nlink;
    state_next      = state;
    ord_next        = ord;
    pg_next         = pg;
    lvl_next        = lvl;
    off_next        = off;
    zone_next       = zone;
    hold_next       = hold;
    mask_next       = mask;
    res_status_next = res_status;
    res_page_next   = res_page;
    for (int i = 0; i < NUM_ORDERS; i++) begin
      list_first_next[i] = list_first[i];
    end
    meta_req = '0;
    link_req = '0;
    rest     = zone - off;
    kcut     = '0;
    for (int i = 0; i < NUM_ORDERS; i++) begin
      if ((LINK_W'(1) << i) <= rest) begin
        kcut = ORD_W'(i);
      end
    end
    sidx  = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_ORDERS; i++) begin
      if (!found && mask[i] && (4'(i) >= ord)) begin
        sidx  = ORD_W'(i);
        found = 1'b1;
      end
    end
    nl    = lvl - ORD_W'(1);
    bud   = pg ^ (PAGE_W'(1) << lvl);
    nlink = list_first[lvl];

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ord_next        = s_tdata[3:0];
          pg_next         = s_tdata[9:4];
          res_status_next = ST_OK;
          res_page_next   = '0;
          case (s_tuser)
            ACT_INIT:  state_next = S_INIT_CLR;
            ACT_ALLOC: state_next = S_A_FIND;
            ACT_FREE:  state_next = S_F_CHK;
            default:   state_next = S_DONE;
          endcase
        end
      end
      // empty lists and metadata, sample zone size
      S_INIT_CLR: begin
        meta_req.clr = 1'b1;
        for (int i = 0; i < NUM_ORDERS; i++) begin
          list_first_next[i] = NIL_LINK;
        end
        mask_next  = '0;
        zone_next  = (page_count > MAX_PAGES) ? MAX_PAGES : page_count;
        off_next   = '0;
        state_next = S_INIT_CUT;
      end
      // one head block per cycle onto an empty list
      S_INIT_CUT: begin
        if (off < zone) begin
          meta_req.wr_en     = 1'b1;
          meta_req.wr_addr   = off[PAGE_W-1:0];
          meta_req.wr_data   = '{in_use: 1'b0, head: 1'b1, order: kcut};
          link_req.nx_we     = 1'b1;
          link_req.nx_addr   = off[PAGE_W-1:0];
          link_req.nx_data   = NIL_LINK;
          link_req.pv_we     = 1'b1;
          link_req.pv_addr   = off[PAGE_W-1:0];
          link_req.pv_data   = NIL_LINK;
          list_first_next[kcut] = off;
          mask_next[kcut]    = 1'b1;
          off_next           = off + (LINK_W'(1) << kcut);
        end else begin
          state_next = S_DONE;
        end
      end
      // smallest non-empty order at or above the request
      S_A_FIND: begin
        if (ord >= 4'(NUM_ORDERS)) begin
          res_status_next = ST_BADORD;
          state_next      = S_DONE;
        end else if (!found) begin
          res_status_next = ST_NOSPACE;
          state_next      = S_DONE;
        end else begin
          lvl_next         = sidx;
          pg_next          = list_first[sidx][PAGE_W-1:0];
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = list_first[sidx][PAGE_W-1:0];
          state_next       = S_A_UNLINK;
        end
      end
      // pop the list head
      S_A_UNLINK: begin
        list_first_next[lvl] = link_rd.nx;
        mask_next[lvl]       = (link_rd.nx != NIL_LINK);
        if (link_rd.nx != NIL_LINK) begin
          link_req.pv_we   = 1'b1;
          link_req.pv_addr = link_rd.nx[PAGE_W-1:0];
          link_req.pv_data = NIL_LINK;
        end
        state_next = S_A_SPLIT;
      end
      // halve once per cycle, upper half onto its (empty) list
      S_A_SPLIT: begin
        if ({1'b0, lvl} > ord) begin
          meta_req.wr_en   = 1'b1;
          meta_req.wr_addr = pg | (PAGE_W'(1) << nl);
          meta_req.wr_data = '{in_use: 1'b0, head: 1'b1, order: nl};
          link_req.nx_we   = 1'b1;
          link_req.nx_addr = pg | (PAGE_W'(1) << nl);
          link_req.nx_data = NIL_LINK;
          link_req.pv_we   = 1'b1;
          link_req.pv_addr = pg | (PAGE_W'(1) << nl);
          link_req.pv_data = NIL_LINK;
          list_first_next[nl] = {1'b0, pg | (PAGE_W'(1) << nl)};
          mask_next[nl]    = 1'b1;
          lvl_next         = nl;
        end else begin
          meta_req.wr_en   = 1'b1;
          meta_req.wr_addr = pg;
          meta_req.wr_data = '{in_use: 1'b1, head: 1'b1, order: ord[ORD_W-1:0]};
          res_page_next    = pg;
          state_next       = S_DONE;
        end
      end
      // free: zone check and metadata lookup
      S_F_CHK: begin
        if ({1'b0, pg} >= zone) begin
          state_next = S_DONE;
        end else begin
          meta_req.rd_en   = 1'b1;
          meta_req.rd_addr = pg;
          state_next       = S_F_CHK2;
        end
      end
      S_F_CHK2: begin
        if (meta_rd.in_use && meta_rd.head) begin
          lvl_next   = meta_rd.order;
          state_next = S_F_BUD;
        end else begin
          state_next = S_DONE;
        end
      end
      // look up the buddy
      S_F_BUD: begin
        if ((lvl < ORD_W'(NUM_ORDERS - 1)) && ({1'b0, bud} < zone)) begin
          meta_req.rd_en   = 1'b1;
          meta_req.rd_addr = bud;
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = bud;
          state_next       = S_F_BCHK;
        end else begin
          state_next = S_F_PUSH;
        end
      end
      // merge with a free buddy of equal order
      S_F_BCHK: begin
        if (meta_rd.in_use || !meta_rd.head || (meta_rd.order != lvl)) begin
          state_next = S_F_PUSH;
        end else begin
          if (link_rd.pv != NIL_LINK) begin
            link_req.nx_we   = 1'b1;
            link_req.nx_addr = link_rd.pv[PAGE_W-1:0];
            link_req.nx_data = link_rd.nx;
          end else begin
            list_first_next[lvl] = link_rd.nx;
            mask_next[lvl]       = (link_rd.nx != NIL_LINK);
          end
          if (link_rd.nx != NIL_LINK) begin
            link_req.pv_we   = 1'b1;
            link_req.pv_addr = link_rd.nx[PAGE_W-1:0];
            link_req.pv_data = link_rd.pv;
          end
          meta_req.wr_en   = 1'b1;
          meta_req.wr_addr = (bud < pg) ? pg : bud;
          meta_req.wr_data = '{in_use: 1'b0, head: 1'b0, order: lvl};
          if (bud < pg) begin
            pg_next = bud;
          end
          lvl_next   = lvl + ORD_W'(1);
          state_next = S_F_BUD;
        end
      end
      // push merged block at the list head
      S_F_PUSH: begin
        meta_req.wr_en   = 1'b1;
        meta_req.wr_addr = pg;
        meta_req.wr_data = '{in_use: 1'b0, head: 1'b1, order: lvl};
        link_req.nx_we   = 1'b1;
        link_req.nx_addr = pg;
        link_req.nx_data = nlink;
        link_req.pv_we   = 1'b1;
        link_req.pv_addr = pg;
        link_req.pv_data = NIL_LINK;
        list_first_next[lvl] = {1'b0, pg};
        mask_next[lvl]   = 1'b1;
        hold_next        = nlink;
        state_next       = (nlink != NIL_LINK) ? S_F_PUSH2 : S_DONE;
      end
      S_F_PUSH2: begin
        link_req.pv_we   = 1'b1;
        link_req.pv_addr = hold[PAGE_W-1:0];
        link_req.pv_data = {1'b0, pg};
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      zone       <= '0;
      page_count <= 7'd64;
      mask       <= '0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
        list_first[i] <= NIL_LINK;
      end
    end else begin
      state <= state_next;
      zone  <= zone_next;
      mask  <= mask_next;
      for (int i = 0; i < NUM_ORDERS; i++) begin
        list_first[i] <= list_first_next[i];
      end
      if (cfg_valid) begin
        page_count <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    ord        <= ord_next;
    pg         <= pg_next;
    lvl        <= lvl_next;
    off        <= off_next;
    hold       <= hold_next;
    res_status <= res_status_next;
    res_page   <= res_page_next;
    if (out_load) begin
      out_status <= res_status;
      out_page   <= res_page;
    end
  end

  // list occupancy view for checking
  logic [NUM_ORDERS-1:0] occ;
  always_comb begin
    for (int i = 0; i < NUM_ORDERS; i++) begin
      occ[i] = (list_first[i] != NIL_LINK);
    end
  end

  a_mask_match: assert property (@(posedge clk) disable iff (rst) mask == occ)
    else $error("occupancy mask out of step with list heads");
  a_zone_limit: assert property (@(posedge clk) disable iff (rst) zone <= MAX_PAGES)
    else $error("zone size above page count limit");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in work");
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result shown without finished item");

endmodule

// File: sv/bpa_meta_store.sv
// bpa_meta_store: page metadata memory (in-use, head, order) with per-page valid bits
// depends on bpa_pkg
module bpa_meta_store (
  input  logic              clk,
  input  logic              rst,
  input  bpa_pkg::meta_req_t req,
  output bpa_pkg::meta_t     rd_data
);
  import bpa_pkg::*;

  meta_t                mem [NUM_PAGES];
  logic [NUM_PAGES-1:0] vld;
  meta_t                rd_q;
  logic                 rd_vld;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  // valid bits: a page never written since clear reads as zero
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// File: sv/bpa_link_store.sv
// bpa_link_store: next and prev link memories of the free lists
// depends on bpa_pkg
module bpa_link_store (
  input  logic               clk,
  input  bpa_pkg::link_req_t req,
  output bpa_pkg::link_rd_t  rd_data
);
  import bpa_pkg::*;

  logic [LINK_W-1:0] next_mem [NUM_PAGES];
  logic [LINK_W-1:0] prev_mem [NUM_PAGES];

  // next and prev links, one registered read port shared by both
  always_ff @(posedge clk) begin
    if (req.nx_we) begin
      next_mem[req.nx_addr] <= req.nx_data;
    end
    if (req.pv_we) begin
      prev_mem[req.pv_addr] <= req.pv_data;
    end
    if (req.rd_en) begin
      rd_data.nx <= next_mem[req.rd_addr];
      rd_data.pv <= prev_mem[req.rd_addr];
    end
  end

endmodule
